[design/imu_frame_parser_assert.svh]
// Assertion helpers shared by the frame parser modules.
`ifndef IMU_FRAME_PARSER_ASSERT_SVH
`define IMU_FRAME_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("imu_frame_parser: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("imu_frame_parser: next-cycle check failed");

`endif

[design/imu_fp_pkg.sv]
package imu_fp_pkg;

   localparam logic [7:0] SYNC_BYTE  = 8'h55;
   localparam logic [7:0] CODE_TIME  = 8'h50;
   localparam logic [7:0] CODE_ANGLE = 8'h53;

   localparam int PAYLOAD_BYTES = 8;
   localparam int PAYLOAD_IDX_W = $clog2(PAYLOAD_BYTES);
   localparam int KIND_W        = 2;
   localparam int WORD_W        = 16;

   localparam logic [PAYLOAD_IDX_W-1:0] LAST_IDX = PAYLOAD_IDX_W'(PAYLOAD_BYTES - 1);

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]        frame_kind;
      logic signed [WORD_W-1:0] word_x;
      logic signed [WORD_W-1:0] word_y;
      logic signed [WORD_W-1:0] word_z;
      logic signed [WORD_W-1:0] word_extra;
   } frame_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_TYPE    = 3'b010,
      ST_PAYLOAD = 3'b100
   } parse_state_type;

endpackage

[design/imu_fp_channels.sv]
interface imu_fp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface imu_fp_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [imu_fp_pkg::KIND_W-1:0]         frame_kind;
   logic signed [imu_fp_pkg::WORD_W-1:0]  word_x;
   logic signed [imu_fp_pkg::WORD_W-1:0]  word_y;
   logic signed [imu_fp_pkg::WORD_W-1:0]  word_z;
   logic signed [imu_fp_pkg::WORD_W-1:0]  word_extra;

   modport source (output valid, output frame_kind, output word_x, output word_y,
                   output word_z, output word_extra, input ready);
   modport sink (input valid, input frame_kind, input word_x, input word_y,
                 input word_z, input word_extra, output ready);
endinterface

[design/imu_fp_in.sv]
module imu_fp_in (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [7:0]                in_byte,
   output logic                      in_ready,
   input  logic                      advance,
   output imu_fp_pkg::byte_item_type item
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;

   // The register takes a new byte whenever it is empty or its byte moves on.
   assign in_ready = !valid_ff || advance;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_byte;
      end
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;

endmodule

[design/imu_fp_parse.sv]
`include "imu_frame_parser_assert.svh"

module imu_fp_parse (
   input  logic                      clock,
   input  logic                      reset,
   input  imu_fp_pkg::byte_item_type item,
   input  logic                      out_free,
   output logic                      advance,
   output logic                      res_valid,
   output imu_fp_pkg::frame_type     res
);

   imu_fp_pkg::parse_state_type                state_ff, state_in;
   logic [imu_fp_pkg::PAYLOAD_IDX_W-1:0]       idx_ff, idx_in;
   logic [imu_fp_pkg::KIND_W-1:0]              kind_ff, kind_in;
   logic [7:0]                                 store_ff [imu_fp_pkg::PAYLOAD_BYTES];
   logic                                       is_last;
   logic                                       code_ok;
   logic [7:0]                                 code_off;

   assign is_last   = (state_ff == imu_fp_pkg::ST_PAYLOAD) && (idx_ff == imu_fp_pkg::LAST_IDX);
   assign res_valid = item.valid && is_last;
   // Only the byte that completes a frame has to wait for room at the output.
   assign advance   = item.valid && (!is_last || out_free);

   assign code_ok  = (item.data >= imu_fp_pkg::CODE_TIME) && (item.data <= imu_fp_pkg::CODE_ANGLE);
   assign code_off = item.data - imu_fp_pkg::CODE_TIME;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      kind_in  = kind_ff;
      if (advance) begin
         unique case (state_ff)
            imu_fp_pkg::ST_IDLE: begin
               if (item.data == imu_fp_pkg::SYNC_BYTE) begin
                  state_in = imu_fp_pkg::ST_TYPE;
               end
            end
            imu_fp_pkg::ST_TYPE: begin
               // A bad code, the sync byte included, drops back to idle; it does not start a new frame.
               if (code_ok) begin
                  state_in = imu_fp_pkg::ST_PAYLOAD;
                  kind_in  = code_off[imu_fp_pkg::KIND_W-1:0];
                  idx_in   = '0;
               end else begin
                  state_in = imu_fp_pkg::ST_IDLE;
               end
            end
            imu_fp_pkg::ST_PAYLOAD: begin
               idx_in = idx_ff + 1'b1;
               if (is_last) begin
                  state_in = imu_fp_pkg::ST_IDLE;
               end
            end
            default: begin
               state_in = imu_fp_pkg::ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imu_fp_pkg::ST_IDLE;
         idx_ff   <= '0;
         kind_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         kind_ff  <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && (state_ff == imu_fp_pkg::ST_PAYLOAD)) begin
         store_ff[idx_ff] <= item.data;
      end
   end

   // The eighth payload byte is taken straight from the input register.
   assign res.frame_kind = kind_ff;
   assign res.word_x     = {store_ff[1], store_ff[0]};
   assign res.word_y     = {store_ff[3], store_ff[2]};
   assign res.word_z     = {store_ff[5], store_ff[4]};
   assign res.word_extra = {item.data, store_ff[6]};

   `IFP_ASSERT_SAME(a_res_only_in_payload, clock, reset, res_valid,
                    state_ff == imu_fp_pkg::ST_PAYLOAD && idx_ff == imu_fp_pkg::LAST_IDX)
   `IFP_ASSERT_NEXT(a_idle_after_frame, clock, reset, res_valid && advance,
                    state_ff == imu_fp_pkg::ST_IDLE)
   `IFP_ASSERT_NEXT(a_sync_starts_frame, clock, reset,
                    state_ff == imu_fp_pkg::ST_IDLE && advance &&
                    item.data == imu_fp_pkg::SYNC_BYTE,
                    state_ff == imu_fp_pkg::ST_TYPE)

endmodule

[design/imu_fp_out.sv]
`include "imu_frame_parser_assert.svh"

module imu_fp_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_valid,
   input  imu_fp_pkg::frame_type res,
   output logic                  out_free,
   output logic                  out_valid,
   input  logic                  out_ready,
   output imu_fp_pkg::frame_type out_data
);

   logic                  valid_ff;
   logic                  valid_in;
   logic                  load;
   imu_fp_pkg::frame_type data_ff;

   assign out_free = !valid_ff || out_ready;
   assign load     = res_valid && out_free;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   `IFP_ASSERT_SAME(a_no_overwrite, clock, reset, load, !(valid_ff && !out_ready))

endmodule

[design/imu_frame_parser.sv]
// Frame parser for the byte stream of an inertial sensor's serial link.
// req_ch carries one received byte per item (rx_byte). rsp_ch carries one
// decoded frame per item: frame_kind (0 time, 1 acceleration, 2 rotation
// rate, 3 angle) and the four signed little-endian words of the payload.
// Bytes outside a frame are dropped until the sync byte 0x55; the next byte
// must be a type code 0x50..0x53, otherwise the parser returns to idle.
// Eight payload bytes follow; the checksum after them is not checked.
// The frame goes into the output register from the input register holding
// its eighth payload byte once the output is free; rsp_ch takes it there.
// Throughput: one byte per cycle while the output has room, set by the
// input register and the single parse stage behind it.
// When the receiver stalls, the finished frame waits in the output register
// while bytes keep flowing; only a byte that completes a second frame holds
// in the input register, and req_ch.ready drops until the output is taken.
// Reset is synchronous: the parser goes idle and both registers empty; the
// payload bytes themselves are not cleared.
module imu_frame_parser (
   input logic                clock,
   input logic                reset,
   imu_fp_req_if.sink         req_ch,
   imu_fp_rsp_if.source       rsp_ch
);

   imu_fp_pkg::byte_item_type item;
   imu_fp_pkg::frame_type     res;
   imu_fp_pkg::frame_type     out_data;
   logic                      advance;
   logic                      res_valid;
   logic                      out_free;

   imu_fp_in u_in (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_byte  (req_ch.rx_byte),
      .in_ready (req_ch.ready),
      .advance  (advance),
      .item     (item)
   );

   imu_fp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .out_free  (out_free),
      .advance   (advance),
      .res_valid (res_valid),
      .res       (res)
   );

   imu_fp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_data)
   );

   assign rsp_ch.frame_kind = out_data.frame_kind;
   assign rsp_ch.word_x     = out_data.word_x;
   assign rsp_ch.word_y     = out_data.word_y;
   assign rsp_ch.word_z     = out_data.word_z;
   assign rsp_ch.word_extra = out_data.word_extra;

endmodule

[test/imu_frame_checker.sv]
module imu_frame_checker (
   input  logic   clock,
   input  logic   reset,
   imu_fp_req_if  req_ch,
   imu_fp_rsp_if  rsp_ch,
   output int     mismatch_count,
   output int     frames_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_TYPE  = 4'd1;
   localparam logic [3:0] PH_FIRST = 4'd2;
   localparam logic [3:0] PH_DONE  = 4'd10;

   logic [3:0]                    parse_phase;
   logic [imu_fp_pkg::KIND_W-1:0] held_kind;
   logic [7:0]                    payload_bytes [imu_fp_pkg::PAYLOAD_BYTES];
   imu_fp_pkg::frame_type         expected_frames [$];

   initial begin
      mismatch_count = 0;
      frames_pending = 0;
      parse_phase    = PH_IDLE;
      held_kind      = '0;
   end

   // Advances the parser by one received byte and queues a frame when the
   // eighth payload byte completes it.
   task automatic parse_byte(input logic [7:0] rx);
      imu_fp_pkg::frame_type decoded;
      logic [7:0]            code_off;
      if (parse_phase == PH_TYPE) begin
         if (rx >= imu_fp_pkg::CODE_TIME && rx <= imu_fp_pkg::CODE_ANGLE) begin
            code_off    = rx - imu_fp_pkg::CODE_TIME;
            held_kind   = code_off[imu_fp_pkg::KIND_W-1:0];
            parse_phase = PH_FIRST;
         end else begin
            parse_phase = PH_IDLE;
         end
      end else if (parse_phase >= PH_FIRST && parse_phase < PH_DONE) begin
         payload_bytes[3'(parse_phase - PH_FIRST)] = rx;
         parse_phase = parse_phase + 4'd1;
         if (parse_phase == PH_DONE) begin
            decoded.frame_kind = held_kind;
            decoded.word_x     = {payload_bytes[1], payload_bytes[0]};
            decoded.word_y     = {payload_bytes[3], payload_bytes[2]};
            decoded.word_z     = {payload_bytes[5], payload_bytes[4]};
            decoded.word_extra = {payload_bytes[7], payload_bytes[6]};
            expected_frames.push_back(decoded);
            parse_phase = PH_IDLE;
         end
      end else begin
         // Anything else, including phases that cannot be reached, acts as idle.
         parse_phase = (rx == imu_fp_pkg::SYNC_BYTE) ? PH_TYPE : PH_IDLE;
      end
   endtask

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_frame();
      imu_fp_pkg::frame_type want;
      if (expected_frames.size() == 0) begin
         $display("%0t: frame with no expected item, actual kind %0d x %0d y %0d z %0d e %0d",
                  $time, rsp_ch.frame_kind, rsp_ch.word_x, rsp_ch.word_y, rsp_ch.word_z,
                  rsp_ch.word_extra);
         mismatch_count++;
      end else begin
         want = expected_frames.pop_front();
         compare_field("frame_kind", want.frame_kind, rsp_ch.frame_kind);
         compare_field("word_x", want.word_x, rsp_ch.word_x);
         compare_field("word_y", want.word_y, rsp_ch.word_y);
         compare_field("word_z", want.word_z, rsp_ch.word_z);
         compare_field("word_extra", want.word_extra, rsp_ch.word_extra);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         parse_phase = PH_IDLE;
         held_kind   = '0;
         expected_frames.delete();
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            check_frame();
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            parse_byte(req_ch.rx_byte);
         end
      end
      frames_pending = expected_frames.size();
   end

endmodule

[test/imu_frame_parser_tb.sv]
module imu_frame_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 300;

   logic clock = 1'b0;
   logic reset;

   imu_fp_req_if req_if ();
   imu_fp_rsp_if rsp_if ();

   int mismatch_count;
   int frames_pending;
   int tx_idle_pct;
   int rx_idle_pct;
   int counted_items;
   int cycle_count;
   bit hold_armed;
   bit hold_served;

   imu_frame_parser u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   imu_frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_if),
      .rsp_ch         (rsp_if),
      .mismatch_count (mismatch_count),
      .frames_pending (frames_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** imu_frame_parser: FAILED **");
      $finish;
   end

   // Receiver: random back-pressure, plus one long hold-off when armed.
   initial begin
      rsp_if.ready = 1'b0;
      hold_served  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_served) begin
            rsp_if.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_served = 1'b1;
         end else begin
            rsp_if.ready = ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Offers one byte and returns at the falling edge after it is taken, with
   // valid still high so that the next item can follow without a gap.
   task automatic send_byte(input logic [7:0] rx);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid   = 1'b1;
      req_if.rx_byte = rx;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      @(negedge clock);
   endtask

   function automatic logic [7:0] payload_value();
      logic [7:0] corner [5];
      corner = '{8'h00, 8'hFF, 8'h7F, 8'h80, imu_fp_pkg::SYNC_BYTE};
      if ($urandom_range(99) < 20) return corner[$urandom_range(4)];
      return 8'($urandom_range(255));
   endfunction

   task automatic send_frame();
      send_byte(imu_fp_pkg::SYNC_BYTE);
      send_byte(imu_fp_pkg::CODE_TIME + 8'($urandom_range(3)));
      repeat (imu_fp_pkg::PAYLOAD_BYTES) send_byte(payload_value());
      // The checksum is not verified; sometimes it is a sync byte on purpose.
      send_byte(($urandom_range(9) == 0) ? imu_fp_pkg::SYNC_BYTE : 8'($urandom_range(255)));
      counted_items += imu_fp_pkg::PAYLOAD_BYTES + 3;
   endtask

   task automatic send_broken();
      logic [7:0] code;
      int         cut;
      int         noise;
      case ($urandom_range(2))
         0: begin
            noise = $urandom_range(5, 1);
            repeat (noise) send_byte(8'($urandom_range(255)));
            counted_items += noise;
         end
         1: begin
            do code = 8'($urandom_range(255));
            while (code >= imu_fp_pkg::CODE_TIME && code <= imu_fp_pkg::CODE_ANGLE);
            send_byte(imu_fp_pkg::SYNC_BYTE);
            send_byte(code);
            counted_items += 2;
         end
         default: begin
            cut = $urandom_range(imu_fp_pkg::PAYLOAD_BYTES - 1);
            send_byte(imu_fp_pkg::SYNC_BYTE);
            send_byte(imu_fp_pkg::CODE_TIME + 8'($urandom_range(3)));
            repeat (cut) send_byte(payload_value());
            counted_items += cut + 2;
         end
      endcase
   endtask

   task automatic wait_for_frames();
      req_if.valid = 1'b0;
      @(negedge clock);
      while (frames_pending != 0) @(negedge clock);
   endtask

   task automatic run_random(input int item_target);
      while (counted_items < item_target) begin
         if ($urandom_range(99) < 75) send_frame();
         else send_broken();
      end
   endtask

   initial begin
      logic [7:0] opening [18];
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.rx_byte = 8'h00;
      tx_idle_pct    = 0;
      rx_idle_pct    = 0;
      counted_items  = 0;
      hold_armed     = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Noise before sync, a time frame with the extreme words and sync bytes
      // in its payload, a sync checksum that opens a new frame, a sync byte in
      // the type position, and codes just outside the valid range.
      opening = '{8'h00, 8'hFF, imu_fp_pkg::SYNC_BYTE, imu_fp_pkg::CODE_TIME,
                  8'h00, 8'h80, 8'hFF, 8'h7F, imu_fp_pkg::SYNC_BYTE,
                  imu_fp_pkg::SYNC_BYTE, 8'hFF, 8'hFF,
                  imu_fp_pkg::SYNC_BYTE, imu_fp_pkg::SYNC_BYTE,
                  imu_fp_pkg::SYNC_BYTE, imu_fp_pkg::CODE_TIME - 8'h01,
                  imu_fp_pkg::SYNC_BYTE, imu_fp_pkg::CODE_ANGLE + 8'h01};
      foreach (opening[i]) send_byte(opening[i]);
      counted_items = 18;
      wait_for_frames();

      tx_idle_pct = 38;
      rx_idle_pct = 73;
      run_random(230);
      wait_for_frames();

      tx_idle_pct = 73;
      rx_idle_pct = 38;
      run_random(450);
      wait_for_frames();

      // Full rate; the long receiver hold-off lets the parser fill and stall.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_armed  = 1'b1;
      run_random(650);
      wait_for_frames();

      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && frames_pending == 0) begin
         $display("** imu_frame_parser: PASSED **");
      end else begin
         $display("** imu_frame_parser: FAILED **");
      end
      $finish;
   end

endmodule
